// ===== design/mtq_pkg.sv =====
package mtq_pkg;

   localparam int DEF_PRIORITY_LEVELS = 4;
   localparam int DEF_MAX_TASKS       = 32;
   localparam int DEF_HANDLER_BITS    = 8;
   localparam int DEF_PAYLOAD_BITS    = 32;

   localparam int KIND_BITS   = 2;
   localparam int PRIO_BITS   = 4;
   localparam int LIMIT_BITS  = 6;
   localparam int STATUS_BITS = 2;
   localparam int CSR_BITS    = 2;

   localparam logic [CSR_BITS-1:0] DEFAULT_PRIORITY_RESET = 2'd1;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_ADD     = 2'd0,
      KIND_PROCESS = 2'd1,
      KIND_QUERY   = 2'd2
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_REJECTED  = 2'd1,
      STATUS_DEFAULTED = 2'd2
   } status_type;

   // Operation broadcast to every cell of the row
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_POP    = 2'd2,
      CELL_EVICT  = 2'd3
   } cell_op_type;

endpackage

// ===== design/mtq_cell.sv =====
module mtq_cell
   import mtq_pkg::*;
#(
   parameter int LEVEL_BITS   = 2,
   parameter int HANDLER_BITS = DEF_HANDLER_BITS,
   parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cell_op_type             op,
   input  logic [LEVEL_BITS-1:0]   key_level,
   input  logic [HANDLER_BITS-1:0] new_handler,
   input  logic [PAYLOAD_BITS-1:0] new_payload,
   input  logic                    left_valid,
   input  logic [LEVEL_BITS-1:0]   left_level,
   input  logic [HANDLER_BITS-1:0] left_handler,
   input  logic [PAYLOAD_BITS-1:0] left_payload,
   input  logic                    left_match,
   input  logic                    right_valid,
   input  logic [LEVEL_BITS-1:0]   right_level,
   input  logic [HANDLER_BITS-1:0] right_handler,
   input  logic [PAYLOAD_BITS-1:0] right_payload,
   output logic                    valid,
   output logic [LEVEL_BITS-1:0]   level,
   output logic [HANDLER_BITS-1:0] handler,
   output logic [PAYLOAD_BITS-1:0] payload,
   output logic                    match
);

   logic                    valid_ff, valid_in;
   logic [LEVEL_BITS-1:0]   level_ff, level_in;
   logic [HANDLER_BITS-1:0] handler_ff, handler_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;

   // Insert: this slot belongs behind the new item. Evict: slot is in the lowest level.
   assign match = (op == CELL_INSERT) ? (!valid_ff || (level_ff < key_level))
                                      : (valid_ff && (level_ff == key_level));

   always_comb begin
      valid_in   = valid_ff;
      level_in   = level_ff;
      handler_in = handler_ff;
      payload_in = payload_ff;
      unique case (op)
         CELL_HOLD: begin
         end
         CELL_INSERT: begin
            if (match) begin
               if (left_match) begin
                  // shift right to open the gap
                  valid_in   = left_valid;
                  level_in   = left_level;
                  handler_in = left_handler;
                  payload_in = left_payload;
               end else begin
                  valid_in   = 1'b1;
                  level_in   = key_level;
                  handler_in = new_handler;
                  payload_in = new_payload;
               end
            end
         end
         CELL_POP: begin
            valid_in   = right_valid;
            level_in   = right_level;
            handler_in = right_handler;
            payload_in = right_payload;
         end
         CELL_EVICT: begin
            if (match) begin
               valid_in   = right_valid;
               level_in   = right_level;
               handler_in = right_handler;
               payload_in = right_payload;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff   <= level_in;
      handler_ff <= handler_in;
      payload_ff <= payload_in;
   end

   assign valid   = valid_ff;
   assign level   = level_ff;
   assign handler = handler_ff;
   assign payload = payload_ff;

endmodule

// ===== design/multilevel_task_queue_drop_lowest.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  kind, handler, payload, priority_req, limit
// rsp_      out        rsp_valid / rsp_stall  task_*, last, status, dropped, counts
// csr_      in         csr_wr_en              default_priority
//
// A rejected add, a query or an unknown kind goes straight to the result state; an add goes
// through the insert state, after the evict state when the row is full (one shift step each).
// Process gives one result a cycle while the result register is free, one task leaving the
// head cell for each result; the next item is taken once the last result is loaded.
// Reset empties the row and the counters and sets default_priority to 1.
// req_stall is high while an item is in work; rsp_stall holds the result register.
module multilevel_task_queue_drop_lowest
   import mtq_pkg::*;
#(
   parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS,
   parameter int MAX_TASKS       = DEF_MAX_TASKS,
   parameter int HANDLER_BITS    = DEF_HANDLER_BITS,
   parameter int PAYLOAD_BITS    = DEF_PAYLOAD_BITS,
   localparam int LEVEL_BITS     = $clog2(PRIORITY_LEVELS),
   localparam int COUNT_BITS     = $clog2(MAX_TASKS + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [KIND_BITS-1:0]         req_kind,
   input  logic [HANDLER_BITS-1:0]      req_handler,
   input  logic [PAYLOAD_BITS-1:0]      req_payload,
   input  logic signed [PRIO_BITS-1:0]  req_priority_req,
   input  logic [LIMIT_BITS-1:0]        req_limit,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_task_valid,
   output logic [HANDLER_BITS-1:0]      rsp_task_handler,
   output logic [PAYLOAD_BITS-1:0]      rsp_task_payload,
   output logic [LEVEL_BITS-1:0]        rsp_task_level,
   output logic                         rsp_last,
   output logic [STATUS_BITS-1:0]       rsp_status,
   output logic                         rsp_dropped,
   output logic [COUNT_BITS-1:0]        rsp_processed_count,
   output logic [COUNT_BITS-1:0]        rsp_level_depth,
   output logic [COUNT_BITS-1:0]        rsp_total_depth,
   input  logic                         csr_wr_en,
   input  logic [CSR_BITS-1:0]          csr_wr_data
);

   localparam int CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_EVICT    = 5'b00010,
      ST_INSERT   = 5'b00100,
      ST_DISPATCH = 5'b01000,
      ST_RESP     = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [CSR_BITS-1:0]     default_ff, default_in;
   logic [KIND_BITS-1:0]    kind_ff, kind_in;
   logic [HANDLER_BITS-1:0] handler_ff, handler_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;
   logic [LEVEL_BITS-1:0]   lvl_ff, lvl_in;
   logic                    qok_ff, qok_in;
   logic [STATUS_BITS-1:0]  status_ff, status_in;
   logic                    dropped_ff, dropped_in;
   logic [LIMIT_BITS-1:0]   limit_ff, limit_in;
   logic [COUNT_BITS-1:0]   n_ff, n_in;
   logic [COUNT_BITS-1:0]   total_ff, total_in;
   logic [COUNT_BITS-1:0]   level_count_ff [PRIORITY_LEVELS];
   logic [COUNT_BITS-1:0]   level_count_in [PRIORITY_LEVELS];

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    task_valid_ff, task_valid_in;
   logic [HANDLER_BITS-1:0] task_handler_ff, task_handler_in;
   logic [PAYLOAD_BITS-1:0] task_payload_ff, task_payload_in;
   logic [LEVEL_BITS-1:0]   task_level_ff, task_level_in;
   logic                    last_ff, last_in;
   logic [STATUS_BITS-1:0]  rstatus_ff, rstatus_in;
   logic                    rdropped_ff, rdropped_in;
   logic [COUNT_BITS-1:0]   processed_ff, processed_in;
   logic [COUNT_BITS-1:0]   depth_ff, depth_in;
   logic [COUNT_BITS-1:0]   rtotal_ff, rtotal_in;

   cell_op_type             cell_op;
   logic [LEVEL_BITS-1:0]   key_level;
   logic                    cell_valid   [MAX_TASKS];
   logic [LEVEL_BITS-1:0]   cell_level   [MAX_TASKS];
   logic [HANDLER_BITS-1:0] cell_handler [MAX_TASKS];
   logic [PAYLOAD_BITS-1:0] cell_payload [MAX_TASKS];
   logic                    cell_match   [MAX_TASKS];

   logic                    accept, rsp_load, preq_ok, inc_en, dec_en, last_pop;
   logic [LEVEL_BITS-1:0]   preq_lvl, dflt_lvl, dec_lvl;
   logic [COUNT_BITS-1:0]   n_next;

   // ---------------- row of cells ----------------
   for (genvar j = 0; j < MAX_TASKS; j++) begin : g_cell
      logic                    l_valid, l_match, r_valid;
      logic [LEVEL_BITS-1:0]   l_level, r_level;
      logic [HANDLER_BITS-1:0] l_handler, r_handler;
      logic [PAYLOAD_BITS-1:0] l_payload, r_payload;

      if (j == 0) begin : g_head
         assign l_valid   = 1'b0;
         assign l_level   = '0;
         assign l_handler = '0;
         assign l_payload = '0;
         assign l_match   = 1'b0;
      end else begin : g_mid
         assign l_valid   = cell_valid[j-1];
         assign l_level   = cell_level[j-1];
         assign l_handler = cell_handler[j-1];
         assign l_payload = cell_payload[j-1];
         assign l_match   = cell_match[j-1];
      end

      if (j == MAX_TASKS - 1) begin : g_tail
         assign r_valid   = 1'b0;
         assign r_level   = '0;
         assign r_handler = '0;
         assign r_payload = '0;
      end else begin : g_body
         assign r_valid   = cell_valid[j+1];
         assign r_level   = cell_level[j+1];
         assign r_handler = cell_handler[j+1];
         assign r_payload = cell_payload[j+1];
      end

      mtq_cell #(
         .LEVEL_BITS   (LEVEL_BITS),
         .HANDLER_BITS (HANDLER_BITS),
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .op            (cell_op),
         .key_level     (key_level),
         .new_handler   (handler_ff),
         .new_payload   (payload_ff),
         .left_valid    (l_valid),
         .left_level    (l_level),
         .left_handler  (l_handler),
         .left_payload  (l_payload),
         .left_match    (l_match),
         .right_valid   (r_valid),
         .right_level   (r_level),
         .right_handler (r_handler),
         .right_payload (r_payload),
         .valid         (cell_valid[j]),
         .level         (cell_level[j]),
         .handler       (cell_handler[j]),
         .payload       (cell_payload[j]),
         .match         (cell_match[j])
      );
   end

   // ---------------- request decode ----------------
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_load  = !rsp_valid_ff || !rsp_stall;

   // a negative request has its top bit set and fails the compare
   assign preq_ok  = $unsigned(req_priority_req) < PRIO_BITS'(PRIORITY_LEVELS);
   assign preq_lvl = LEVEL_BITS'($unsigned(req_priority_req));
   assign dflt_lvl = (PRIO_BITS'(default_ff) < PRIO_BITS'(PRIORITY_LEVELS))
                     ? LEVEL_BITS'(default_ff) : LEVEL_BITS'(PRIORITY_LEVELS - 1);

   assign n_next   = n_ff + COUNT_BITS'(1);
   assign last_pop = (total_ff == COUNT_BITS'(1)) ||
                     ((limit_ff != '0) && (CMP_BITS'(n_next) == CMP_BITS'(limit_ff)));

   always_comb begin
      state_in   = state_ff;
      default_in = csr_wr_en ? csr_wr_data : default_ff;
      kind_in    = kind_ff;
      handler_in = handler_ff;
      payload_in = payload_ff;
      lvl_in     = lvl_ff;
      qok_in     = qok_ff;
      status_in  = status_ff;
      dropped_in = dropped_ff;
      limit_in   = limit_ff;
      n_in       = n_ff;

      cell_op    = CELL_HOLD;
      key_level  = lvl_ff;
      inc_en     = 1'b0;
      dec_en     = 1'b0;
      dec_lvl    = cell_level[0];

      rsp_valid_in    = (rsp_valid_ff && rsp_stall);
      task_valid_in   = task_valid_ff;
      task_handler_in = task_handler_ff;
      task_payload_in = task_payload_ff;
      task_level_in   = task_level_ff;
      last_in         = last_ff;
      rstatus_in      = rstatus_ff;
      rdropped_in     = rdropped_ff;
      processed_in    = processed_ff;
      depth_in        = depth_ff;
      rtotal_in       = rtotal_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in    = req_kind;
               handler_in = req_handler;
               payload_in = req_payload;
               lvl_in     = preq_ok ? preq_lvl : dflt_lvl;
               qok_in     = preq_ok;
               limit_in   = req_limit;
               n_in       = '0;
               dropped_in = 1'b0;
               status_in  = STATUS_OK;
               unique case (req_kind)
                  KIND_ADD: begin
                     if (req_handler == '0) begin
                        status_in = STATUS_REJECTED;
                        state_in  = ST_RESP;
                     end else begin
                        if (!preq_ok) begin
                           status_in = STATUS_DEFAULTED;
                        end
                        state_in = (total_ff == COUNT_BITS'(MAX_TASKS)) ? ST_EVICT : ST_INSERT;
                     end
                  end
                  KIND_PROCESS: state_in = ST_DISPATCH;
                  default:      state_in = ST_RESP;
               endcase
            end
         end
         ST_EVICT: begin
            // row is full, so the tail cell holds the lowest non-empty level
            cell_op    = CELL_EVICT;
            key_level  = cell_level[MAX_TASKS-1];
            dec_en     = 1'b1;
            dec_lvl    = cell_level[MAX_TASKS-1];
            dropped_in = 1'b1;
            state_in   = ST_INSERT;
         end
         ST_INSERT: begin
            cell_op  = CELL_INSERT;
            inc_en   = 1'b1;
            state_in = ST_RESP;
         end
         ST_DISPATCH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rstatus_in   = STATUS_OK;
               rdropped_in  = 1'b0;
               depth_in     = '0;
               if (cell_valid[0]) begin
                  cell_op         = CELL_POP;
                  dec_en          = 1'b1;
                  task_valid_in   = 1'b1;
                  task_handler_in = cell_handler[0];
                  task_payload_in = cell_payload[0];
                  task_level_in   = cell_level[0];
                  processed_in    = n_next;
                  rtotal_in       = total_ff - COUNT_BITS'(1);
                  last_in         = last_pop;
                  n_in            = n_next;
                  if (last_pop) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  // nothing held: one empty result
                  task_valid_in   = 1'b0;
                  task_handler_in = '0;
                  task_payload_in = '0;
                  task_level_in   = '0;
                  processed_in    = '0;
                  rtotal_in       = total_ff;
                  last_in         = 1'b1;
                  state_in        = ST_IDLE;
               end
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in    = 1'b1;
               task_valid_in   = 1'b0;
               task_handler_in = '0;
               task_payload_in = '0;
               task_level_in   = '0;
               last_in         = 1'b1;
               rstatus_in      = status_ff;
               rdropped_in     = dropped_ff;
               processed_in    = '0;
               depth_in        = ((kind_ff == KIND_QUERY) && qok_ff) ? level_count_ff[lvl_ff]
                                                                     : '0;
               rtotal_in       = total_ff;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // per-level and total counters
   always_comb begin
      for (int l = 0; l < PRIORITY_LEVELS; l++) begin
         level_count_in[l] = level_count_ff[l];
         if (inc_en && (lvl_ff == LEVEL_BITS'(l))) begin
            level_count_in[l] = level_count_ff[l] + COUNT_BITS'(1);
         end
         if (dec_en && (dec_lvl == LEVEL_BITS'(l))) begin
            level_count_in[l] = level_count_ff[l] - COUNT_BITS'(1);
         end
      end
      total_in = total_ff;
      if (inc_en) begin
         total_in = total_ff + COUNT_BITS'(1);
      end else if (dec_en) begin
         total_in = total_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         default_ff   <= DEFAULT_PRIORITY_RESET;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < PRIORITY_LEVELS; l++) begin
            level_count_ff[l] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         default_ff   <= default_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int l = 0; l < PRIORITY_LEVELS; l++) begin
            level_count_ff[l] <= level_count_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff         <= kind_in;
      handler_ff      <= handler_in;
      payload_ff      <= payload_in;
      lvl_ff          <= lvl_in;
      qok_ff          <= qok_in;
      status_ff       <= status_in;
      dropped_ff      <= dropped_in;
      limit_ff        <= limit_in;
      n_ff            <= n_in;
      task_valid_ff   <= task_valid_in;
      task_handler_ff <= task_handler_in;
      task_payload_ff <= task_payload_in;
      task_level_ff   <= task_level_in;
      last_ff         <= last_in;
      rstatus_ff      <= rstatus_in;
      rdropped_ff     <= rdropped_in;
      processed_ff    <= processed_in;
      depth_ff        <= depth_in;
      rtotal_ff       <= rtotal_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_task_valid      = task_valid_ff;
   assign rsp_task_handler    = task_handler_ff;
   assign rsp_task_payload    = task_payload_ff;
   assign rsp_task_level      = task_level_ff;
   assign rsp_last            = last_ff;
   assign rsp_status          = rstatus_ff;
   assign rsp_dropped         = rdropped_ff;
   assign rsp_processed_count = processed_ff;
   assign rsp_level_depth     = depth_ff;
   assign rsp_total_depth     = rtotal_ff;

endmodule
